// ===== rtl/ftch_pkg.sv =====
// Shared types, constants and the arctangent table of the compass heading block.
package ftch_pkg;

	localparam int MagW      = 16;
	localparam int AvgW      = 24;
	localparam int DotW      = 41;
	localparam int VecW      = 59;
	localparam int AccW      = 60;
	localparam int OpAW      = 25;
	localparam int OpBW      = 17;
	localparam int ProdW     = OpAW + OpBW;
	localparam int DefSteps  = 16;
	localparam int OneGSq    = 4194304;
	localparam int HalfTurn  = 18000;
	localparam int FullTurn  = 36000;
	localparam int ZMax      = 589824000;

	typedef struct packed {
		logic signed [MagW-1:0] mag_x;
		logic signed [MagW-1:0] mag_y;
		logic signed [MagW-1:0] mag_z;
		logic signed [MagW-1:0] accel_x;
		logic signed [MagW-1:0] accel_y;
		logic signed [MagW-1:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic [15:0]            heading_tilt;
		logic [15:0]            heading_plain;
		logic signed [MagW-1:0] filt_x;
		logic signed [MagW-1:0] filt_y;
		logic signed [MagW-1:0] filt_z;
		logic                   accel_normalised;
	} heading_t;

	typedef enum logic {
		REG_WEIGHT   = 1'b0,
		REG_MIN_NORM = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {SH_0, SH_8, SH_16, SH_24} mac_shift_t;
	typedef enum logic [1:0] {BASE_ACC, BASE_ZERO, BASE_ROUND} mac_base_t;

	typedef struct packed {
		logic signed [OpAW-1:0] op_a;
		logic signed [OpBW-1:0] op_b;
		mac_shift_t             shift;
		logic                   sub;
		mac_base_t              base;
	} mac_ctl_t;

	// atan(2^-i) in 0.01 degree, Q16
	function automatic logic [28:0] atan_q16(input logic [4:0] i);
		logic [28:0] r;
		unique case (i)
			5'd0:  r = 29'd294912000;
			5'd1:  r = 29'd174096719;
			5'd2:  r = 29'd91987925;
			5'd3:  r = 29'd46694507;
			5'd4:  r = 29'd23437865;
			5'd5:  r = 29'd11730358;
			5'd6:  r = 29'd5866610;
			5'd7:  r = 29'd2933484;
			5'd8:  r = 29'd1466764;
			5'd9:  r = 29'd733385;
			5'd10: r = 29'd366693;
			5'd11: r = 29'd183346;
			5'd12: r = 29'd91673;
			5'd13: r = 29'd45837;
			5'd14: r = 29'd22918;
			5'd15: r = 29'd11459;
			5'd16: r = 29'd5730;
			5'd17: r = 29'd2865;
			5'd18: r = 29'd1432;
			5'd19: r = 29'd716;
			5'd20: r = 29'd358;
			5'd21: r = 29'd179;
			5'd22: r = 29'd90;
			5'd23: r = 29'd45;
			default: r = 29'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/ftch_stream_if.sv =====
// Valid/ready channel carrying one item.
interface ftch_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/ftch_mac.sv =====
// Shared multiply-accumulate unit: registered product, then shifted add or subtract.
module ftch_mac import ftch_pkg::*; (
	input  logic                   clk,
	input  logic                   mul_en,
	input  logic                   acc_en,
	input  mac_ctl_t               ctl,
	output logic signed [AccW-1:0] acc_d
);
	logic signed [ProdW-1:0] prod_s1;
	logic signed [AccW-1:0]  acc_q;
	logic signed [AccW-1:0]  prod_ext;
	logic signed [AccW-1:0]  term;
	logic signed [AccW-1:0]  base;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= ctl.op_a * ctl.op_b;
		end
		if (acc_en) begin
			acc_q <= acc_d;
		end
	end

	always_comb begin
		prod_ext = AccW'(prod_s1);
		unique case (ctl.shift)
			SH_0:  term = prod_ext;
			SH_8:  term = prod_ext <<< 8;
			SH_16: term = prod_ext <<< 16;
			SH_24: term = prod_ext <<< 24;
			default: term = prod_ext;
		endcase
		unique case (ctl.base)
			BASE_ACC:   base = acc_q;
			BASE_ZERO:  base = '0;
			BASE_ROUND: base = AccW'(128);
			default:    base = '0;
		endcase
		acc_d = ctl.sub ? base - term : base + term;
	end
endmodule

// ===== rtl/ftch_heading.sv =====
// atan2 heading: magnitude normalize, vectoring rotation, quadrant map to 0.01 degree.
module ftch_heading import ftch_pkg::*; #(
	parameter int CORDIC_STEPS = DefSteps
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [VecW-1:0] vec_x,
	input  logic signed [VecW-1:0] vec_y,
	output logic                   done,
	output logic [15:0]            heading
);
	localparam int IW = $clog2(CORDIC_STEPS);

	typedef enum logic [1:0] {H_IDLE, H_NORM, H_ROT, H_FIN} hstate_t;

	hstate_t           state_q;
	logic [VecW-1:0]   ux_q, uy_q, mx;
	logic              xneg_q, yneg_q;
	logic signed [32:0] cx_q, cy_q, sx, sy;
	logic signed [31:0] z_q, zc, zr;
	logic [IW-1:0]     i_q;
	logic [13:0]       ang;
	logic [15:0]       h;
	logic              done_q;
	logic [15:0]       heading_q;

	assign mx = (ux_q > uy_q) ? ux_q : uy_q;
	assign sx = cx_q >>> i_q;
	assign sy = cy_q >>> i_q;

	always_comb begin
		if (z_q < 0) begin
			zc = '0;
		end else if (z_q > 32'(ZMax)) begin
			zc = 32'(ZMax);
		end else begin
			zc = z_q;
		end
		zr  = zc + 32'sd32768;
		ang = zr[29:16];
		priority if (!xneg_q && !yneg_q) begin
			h = {2'b0, ang};
		end else if (xneg_q && !yneg_q) begin
			h = 16'(HalfTurn) - {2'b0, ang};
		end else if (xneg_q) begin
			h = 16'(HalfTurn) + {2'b0, ang};
		end else begin
			h = (ang == '0) ? '0 : 16'(FullTurn) - {2'b0, ang};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				H_IDLE: begin
					done_q <= start && vec_x == '0 && vec_y == '0;
					if (start) begin
						if (vec_x == '0 && vec_y == '0) begin
							heading_q <= '0;
						end else begin
							state_q <= H_NORM;
						end
					end
				end
				H_NORM: begin
					if (mx[VecW-1:30] == '0 && mx[29]) begin
						state_q <= H_ROT;
					end
				end
				H_ROT: begin
					if (i_q == IW'(CORDIC_STEPS - 1)) begin
						state_q <= H_FIN;
					end
				end
				H_FIN: begin
					heading_q <= h;
					done_q    <= 1'b1;
					state_q   <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == H_IDLE && start) begin
			xneg_q <= vec_x[VecW-1];
			yneg_q <= vec_y[VecW-1];
			ux_q   <= vec_x[VecW-1] ? VecW'(-vec_x) : VecW'(vec_x);
			uy_q   <= vec_y[VecW-1] ? VecW'(-vec_y) : VecW'(vec_y);
		end
		if (state_q == H_NORM) begin
			if (mx[VecW-1:30] != '0) begin
				ux_q <= ux_q >> 1;
				uy_q <= uy_q >> 1;
			end else if (!mx[29]) begin
				ux_q <= ux_q << 1;
				uy_q <= uy_q << 1;
			end
			cx_q <= {3'b0, ux_q[29:0]};
			cy_q <= {3'b0, uy_q[29:0]};
			z_q  <= '0;
			i_q  <= '0;
		end
		if (state_q == H_ROT) begin
			if (!cy_q[32]) begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				z_q  <= z_q + 32'(atan_q16(5'(i_q)));
			end else begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				z_q  <= z_q - 32'(atan_q16(5'(i_q)));
			end
			i_q <= i_q + 1'b1;
		end
	end

	assign done    = done_q;
	assign heading = heading_q;
endmodule

// ===== rtl/filtered_tilt_compass_heading.sv =====
// Top level: sequencer, filter and tilt state around the shared MAC and heading unit.
// Each item runs 21 multiply-accumulate operations, each a multiply state and an accumulate state
// on the one 25x17 multiplier, and then two passes of the heading unit, each up to 29
// one-bit normalize shifts plus CORDIC_STEPS rotation steps (a zero vector skips both and
// gives heading 0).
// samples.ready is high only while the block is idle. The result waits in an output register;
// a following item stalls before its output until that result is taken.
module filtered_tilt_compass_heading import ftch_pkg::*; #(
	parameter int CORDIC_STEPS = DefSteps
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_idx,
	input  logic [14:0]          cfg_data,
	ftch_stream_if.sink          samples,
	ftch_stream_if.source        result
);
	localparam logic [4:0] LastStep = 5'd20;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_HP, S_HPW, S_HT, S_HTW, S_OUT} state_t;
	typedef enum logic [3:0] {
		WR_NONE, WR_AVGX, WR_AVGY, WR_AVGZ, WR_THR2, WR_A2, WR_DOT, WR_X, WR_Y
	} wr_dst_t;

	state_t                 state_q;
	logic [4:0]             step_q;
	logic [8:0]             weight_q;
	logic [14:0]            thr_q;
	logic signed [AvgW-1:0] avg_x_q, avg_y_q, avg_z_q;
	sample_t                samp_q;
	logic [29:0]            thr2_q;
	logic [31:0]            a2_q;
	logic signed [DotW-1:0] dot_q;
	logic signed [VecW-1:0] x_q, y_q;
	logic [15:0]            hp_q;
	logic [15:0]            ht_q;
	heading_t               out_q;
	logic                   out_valid_q;

	logic [8:0]             weff;
	logic                   norm;
	logic [31:0]            dmul;
	mac_ctl_t               ctl;
	wr_dst_t                wr;
	logic signed [AccW-1:0] acc_d;
	logic                   h_start, h_done, h_sel_tilt;
	logic [15:0]            h_val;
	logic signed [VecW-1:0] hx, hy;
	logic                   accept, out_free;

	function automatic logic signed [MagW-1:0] filt(input logic signed [AvgW-1:0] avg);
		logic signed [AvgW:0] s;
		logic signed [AvgW-8:0] f;
		s = (AvgW+1)'(avg) + (AvgW+1)'(128);
		f = (AvgW-7)'(s >>> 8);
		if (f > 17'sd32767) begin
			return 16'sh7fff;
		end else if (f < -17'sd32768) begin
			return 16'sh8000;
		end
		return f[MagW-1:0];
	endfunction

	assign weff = (weight_q > 9'd256) ? 9'd256 : weight_q;
	assign norm = a2_q > {2'b0, thr2_q};
	assign dmul = norm ? a2_q : 32'(OneGSq);

	always_comb begin
		ctl.op_a  = '0;
		ctl.op_b  = '0;
		ctl.shift = SH_0;
		ctl.sub   = 1'b0;
		ctl.base  = BASE_ACC;
		wr        = WR_NONE;
		unique case (step_q)
			5'd0, 5'd2, 5'd4: begin
				ctl.op_a  = (step_q == 5'd0) ? OpAW'(samp_q.mag_x) :
				            (step_q == 5'd2) ? OpAW'(samp_q.mag_y) : OpAW'(samp_q.mag_z);
				ctl.op_b  = {8'b0, weff};
				ctl.shift = SH_8;
				ctl.base  = BASE_ROUND;
			end
			5'd1, 5'd3, 5'd5: begin
				ctl.op_a = (step_q == 5'd1) ? OpAW'(avg_x_q) :
				           (step_q == 5'd3) ? OpAW'(avg_y_q) : OpAW'(avg_z_q);
				ctl.op_b = {8'b0, 9'd256 - weff};
				wr       = (step_q == 5'd1) ? WR_AVGX : (step_q == 5'd3) ? WR_AVGY : WR_AVGZ;
			end
			5'd6: begin
				ctl.op_a = {10'b0, thr_q};
				ctl.op_b = {2'b0, thr_q};
				ctl.base = BASE_ZERO;
				wr       = WR_THR2;
			end
			5'd7: begin
				ctl.op_a = OpAW'(samp_q.accel_x);
				ctl.op_b = OpBW'(samp_q.accel_x);
				ctl.base = BASE_ZERO;
			end
			5'd8: begin
				ctl.op_a = OpAW'(samp_q.accel_y);
				ctl.op_b = OpBW'(samp_q.accel_y);
			end
			5'd9: begin
				ctl.op_a = OpAW'(samp_q.accel_z);
				ctl.op_b = OpBW'(samp_q.accel_z);
				wr       = WR_A2;
			end
			5'd10: begin
				ctl.op_a = OpAW'(avg_x_q);
				ctl.op_b = OpBW'(samp_q.accel_x);
				ctl.base = BASE_ZERO;
			end
			5'd11: begin
				ctl.op_a = OpAW'(avg_y_q);
				ctl.op_b = OpBW'(samp_q.accel_y);
			end
			5'd12: begin
				ctl.op_a = OpAW'(avg_z_q);
				ctl.op_b = OpBW'(samp_q.accel_z);
				wr       = WR_DOT;
			end
			5'd13, 5'd17: begin
				ctl.op_a = (step_q == 5'd13) ? OpAW'(avg_x_q) : OpAW'(avg_y_q);
				ctl.op_b = {1'b0, dmul[15:0]};
				ctl.base = BASE_ZERO;
			end
			5'd14, 5'd18: begin
				ctl.op_a  = (step_q == 5'd14) ? OpAW'(avg_x_q) : OpAW'(avg_y_q);
				ctl.op_b  = {1'b0, dmul[31:16]};
				ctl.shift = SH_16;
			end
			5'd15, 5'd19: begin
				ctl.op_a  = (step_q == 5'd15) ? OpAW'(samp_q.accel_x) : OpAW'(samp_q.accel_y);
				ctl.op_b  = dot_q[DotW-1:24];
				ctl.shift = SH_24;
				ctl.sub   = 1'b1;
			end
			5'd16, 5'd20: begin
				ctl.op_a = {1'b0, dot_q[23:0]};
				ctl.op_b = (step_q == 5'd16) ? OpBW'(samp_q.accel_x) : OpBW'(samp_q.accel_y);
				ctl.sub  = 1'b1;
				wr       = (step_q == 5'd16) ? WR_X : WR_Y;
			end
			default: ;
		endcase
	end

	ftch_mac u_mac (
		.clk    (clk),
		.mul_en (state_q == S_MUL),
		.acc_en (state_q == S_ACC),
		.ctl    (ctl),
		.acc_d  (acc_d)
	);

	assign h_start = (state_q == S_HP) || (state_q == S_HT);
	assign h_sel_tilt = (state_q == S_HT);
	assign hx = h_sel_tilt ? x_q : VecW'(avg_x_q);
	assign hy = h_sel_tilt ? y_q : VecW'(avg_y_q);

	ftch_heading #(.CORDIC_STEPS(CORDIC_STEPS)) u_heading (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (h_start),
		.vec_x   (hx),
		.vec_y   (hy),
		.done    (h_done),
		.heading (h_val)
	);

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || result.ready;
	assign result.valid  = out_valid_q;
	assign result.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			weight_q    <= 9'd51;
			thr_q       <= 15'd205;
			avg_x_q     <= '0;
			avg_y_q     <= '0;
			avg_z_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_WEIGHT:   weight_q <= cfg_data[8:0];
					REG_MIN_NORM: thr_q    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= S_MUL;
						if (avg_x_q == '0 && avg_y_q == '0 && avg_z_q == '0) begin
							avg_x_q <= {samples.payload.mag_x, 8'b0};
							avg_y_q <= {samples.payload.mag_y, 8'b0};
							avg_z_q <= {samples.payload.mag_z, 8'b0};
						end
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					unique case (wr)
						WR_AVGX: avg_x_q <= acc_d[31:8];
						WR_AVGY: avg_y_q <= acc_d[31:8];
						WR_AVGZ: avg_z_q <= acc_d[31:8];
						default: ;
					endcase
					if (step_q == LastStep) begin
						state_q <= S_HP;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_HP:  state_q <= S_HPW;
				S_HPW: if (h_done) state_q <= S_HT;
				S_HT:  state_q <= S_HTW;
				S_HTW: if (h_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= samples.payload;
		end
		if (state_q == S_ACC) begin
			unique case (wr)
				WR_THR2: thr2_q <= acc_d[29:0];
				WR_A2:   a2_q   <= acc_d[31:0];
				WR_DOT:  dot_q  <= acc_d[DotW-1:0];
				WR_X:    x_q    <= acc_d[VecW-1:0];
				WR_Y:    y_q    <= acc_d[VecW-1:0];
				default: ;
			endcase
		end
		if (state_q == S_HPW && h_done) begin
			hp_q <= h_val;
		end
		if (state_q == S_HTW && h_done) begin
			ht_q <= h_val;
		end
		if (state_q == S_OUT && out_free) begin
			out_q.heading_tilt     <= ht_q;
			out_q.heading_plain    <= hp_q;
			out_q.filt_x           <= filt(avg_x_q);
			out_q.filt_y           <= filt(avg_y_q);
			out_q.filt_z           <= filt(avg_z_q);
			out_q.accel_normalised <= norm;
		end
	end
endmodule

// ===== verif/filtered_tilt_compass_heading_test.sv =====
// Testbench of the filtered tilt-compensated compass heading block: directed table, random items.
`timescale 1ns / 1ps

module filtered_tilt_compass_heading_test;
	import ftch_pkg::*;

	localparam int      Steps      = DefSteps;
	localparam longint  CycleLimit = 1000000;
	localparam int      StallLen   = 3000;
	localparam int      NumPhases  = 8;
	localparam int      PhaseItems = 125;

	typedef struct {
		int       weight;
		sample_t  s;
		bit       typed;
		heading_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_idx = '0;
	logic [14:0] cfg_data = '0;

	ftch_stream_if #(.payload_t(sample_t))  samples_if ();
	ftch_stream_if #(.payload_t(heading_t)) result_if ();

	filtered_tilt_compass_heading i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.samples (samples_if.sink),
		.result  (result_if.source)
	);

	always #4 clk = ~clk;

	// filter state and registers of the predictor
	int      fx, fy, fz;
	int      weight_reg, norm_reg;
	heading_t expected_q[$];
	int      errors;
	int      n_items, n_results, n_norm, n_wrap;
	bit      calm, stall_req;
	longint  cycles;

	longint atan_lut[24] = '{
		294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
		5866610, 2933484, 1466764, 733385, 366693, 183346,
		91673, 45837, 22918, 11459, 5730, 2865,
		1432, 716, 358, 179, 90, 45
	};

	function automatic logic [15:0] bearing(longint bx, longint by);
		longint ux, uy, mx, x, y, z, nx, ny, a;
		int h;
		if (bx == 0 && by == 0) return 16'd0;
		ux = bx < 0 ? -bx : bx;
		uy = by < 0 ? -by : by;
		mx = ux > uy ? ux : uy;
		while (mx >= (64'sd1 << 30)) begin
			ux = ux >>> 1; uy = uy >>> 1; mx = mx >>> 1;
		end
		while (mx < (64'sd1 << 29)) begin
			ux = ux << 1; uy = uy << 1; mx = mx << 1;
		end
		x = ux; y = uy; z = 0;
		for (int i = 0; i < Steps && i < 24; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_lut[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_lut[i];
			end
			x = nx; y = ny;
		end
		if (z < 0) z = 0;
		if (z > ZMax) z = ZMax;
		a = (z + 32768) >>> 16;
		if (bx >= 0 && by >= 0) h = a;
		else if (bx < 0 && by >= 0) h = HalfTurn - a;
		else if (bx < 0) h = HalfTurn + a;
		else h = FullTurn - a;
		if (h >= FullTurn) h = h - FullTurn;
		return h[15:0];
	endfunction

	function automatic int smooth(int avg, longint m, longint w);
		longint s;
		s = w * (m * 256) + (256 - w) * longint'(avg) + 128;
		return int'(s >>> 8);
	endfunction

	function automatic logic [15:0] to_counts(int avg);
		longint f;
		f = (longint'(avg) + 128) >>> 8;
		if (f > 32767) f = 32767;
		if (f < -32768) f = -32768;
		return f[15:0];
	endfunction

	function automatic heading_t predict_heading(sample_t s);
		heading_t r;
		longint w, ax, ay, az, a2, dd, dot, tx, ty;
		w = weight_reg > 256 ? 256 : weight_reg;
		if (fx == 0 && fy == 0 && fz == 0) begin
			fx = s.mag_x * 256; fy = s.mag_y * 256; fz = s.mag_z * 256;
		end
		fx = smooth(fx, s.mag_x, w);
		fy = smooth(fy, s.mag_y, w);
		fz = smooth(fz, s.mag_z, w);
		ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
		a2 = ax * ax + ay * ay + az * az;
		r.accel_normalised = a2 > longint'(norm_reg) * norm_reg;
		dd = r.accel_normalised ? a2 : OneGSq;
		dot = longint'(fx) * ax + longint'(fy) * ay + longint'(fz) * az;
		tx = longint'(fx) * dd - dot * ax;
		ty = longint'(fy) * dd - dot * ay;
		r.heading_tilt = bearing(tx, ty);
		r.heading_plain = bearing(fx, fy);
		r.filt_x = to_counts(fx);
		r.filt_y = to_counts(fy);
		r.filt_z = to_counts(fz);
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t idx, int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = value[14:0];
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_WEIGHT) weight_reg = value & 'h1FF;
		else norm_reg = value & 'h7FFF;
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic send(sample_t s, bit typed, heading_t r);
		heading_t p;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 22) @(negedge clk);
		samples_if.valid = 1'b1;
		samples_if.payload = s;
		do @(posedge clk); while (!samples_if.ready);
		p = predict_heading(s);
		expected_q.push_back(typed ? r : p);
		n_items++;
		if (p.accel_normalised) n_norm++;
		@(negedge clk);
		samples_if.valid = 1'b0;
	endtask

	function automatic logic [15:0] pick(int lim);
		int v;
		v = $urandom_range(2 * lim) - lim;
		return v[15:0];
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int k;
		k = $urandom_range(9);
		if (k < 8) begin
			s.mag_x = pick(3000); s.mag_y = pick(3000); s.mag_z = pick(3000);
		end else begin
			s.mag_x = $urandom; s.mag_y = $urandom; s.mag_z = $urandom;
		end
		k = $urandom_range(9);
		if (k < 5) begin
			s.accel_x = pick(2600); s.accel_y = pick(2600); s.accel_z = pick(2600);
		end else if (k < 7) begin
			s.accel_x = pick(150); s.accel_y = pick(150); s.accel_z = pick(150);
		end else if (k < 8) begin
			s.accel_x = norm_reg + pick(2); s.accel_y = pick(1); s.accel_z = pick(1);
		end else begin
			s.accel_x = $urandom; s.accel_y = $urandom; s.accel_z = $urandom;
		end
		return s;
	endfunction

	// receiver
	initial begin
		int hold;
		hold = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req && hold == 0) begin
				hold = StallLen;
				stall_req = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				result_if.ready = 1'b0;
			end else begin
				result_if.ready = calm || ($urandom_range(99) >= 22);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		heading_t got, want;
		if (result_if.valid && result_if.ready) begin
			got = result_if.payload;
			n_results++;
			if (expected_q.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.heading_tilt !== want.heading_tilt) begin
					$error("heading_tilt: expected %0d, got %0d", want.heading_tilt,
						got.heading_tilt);
					errors++;
				end
				if (got.heading_plain !== want.heading_plain) begin
					$error("heading_plain: expected %0d, got %0d", want.heading_plain,
						got.heading_plain);
					errors++;
				end
				if (got.filt_x !== want.filt_x) begin
					$error("filt_x: expected %0d, got %0d", want.filt_x, got.filt_x);
					errors++;
				end
				if (got.filt_y !== want.filt_y) begin
					$error("filt_y: expected %0d, got %0d", want.filt_y, got.filt_y);
					errors++;
				end
				if (got.filt_z !== want.filt_z) begin
					$error("filt_z: expected %0d, got %0d", want.filt_z, got.filt_z);
					errors++;
				end
				if (got.accel_normalised !== want.accel_normalised) begin
					$error("accel_normalised: expected %0d, got %0d",
						want.accel_normalised, got.accel_normalised);
					errors++;
				end
				if (want.heading_tilt == 0 && want.heading_plain == 0) n_wrap++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		heading_t zr;
		sample_t s;
		int wsel, nsel;
		samples_if.valid = 1'b0;
		samples_if.payload = '0;
		fx = 0; fy = 0; fz = 0;
		weight_reg = 51; norm_reg = 205;
		errors = 0; n_items = 0; n_results = 0; n_norm = 0; n_wrap = 0;
		calm = 1'b0; stall_req = 1'b0; cycles = 0;
		zr = '0;

		// all zero: filter stays unseeded, zero vector gives heading 0
		rows.push_back('{-1, '{0, 0, 0, 0, 0, 0}, 1'b1, zr});
		// seeds the filter; no accel so tilt path uses 1 g unnormalised
		rw = '{-1, '{100, 0, 0, 0, 0, 0}, 1'b1, zr};
		rw.r.filt_x = 16'sd100;
		rows.push_back(rw);
		rows.push_back('{-1, '{32767, -32768, 32767, 0, 0, 2048}, 1'b0, zr});
		rows.push_back('{-1, '{-32768, 32767, -32768, -32768, -32768, -32768}, 1'b0, zr});
		rows.push_back('{-1, '{-500, -700, 300, 32767, 32767, 32767}, 1'b0, zr});
		rows.push_back('{-1, '{200, -900, 100, 205, 0, 0}, 1'b0, zr});
		rows.push_back('{-1, '{200, -900, 100, 206, 0, 0}, 1'b0, zr});
		rows.push_back('{-1, '{-300, 100, 50, 0, 0, -2048}, 1'b0, zr});
		rows.push_back('{-1, '{-300, -100, 50, 1000, -1500, 600}, 1'b0, zr});
		// weight 256 makes the average follow the sample exactly
		rows.push_back('{256, '{32767, -1, 0, 0, 0, 0}, 1'b0, zr});
		rows.push_back('{-1, '{-32768, 0, 0, 0, 0, 0}, 1'b0, zr});
		rows.push_back('{-1, '{0, -32768, 0, 0, 0, 0}, 1'b0, zr});
		rows.push_back('{-1, '{0, 32767, 0, 0, 0, 0}, 1'b0, zr});
		rows.push_back('{-1, '{-1000, 1000, -1000, 100, 100, 2000}, 1'b0, zr});
		rows.push_back('{-1, '{1000, 1, 0, -1, 1, 1}, 1'b0, zr});
		rows.push_back('{0, '{5, 5, 5, 0, 2048, 0}, 1'b0, zr});
		rows.push_back('{511, '{-7, 3, 9, 0, 0, 2048}, 1'b0, zr});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].weight >= 0) begin
				drain();
				write_reg(REG_WEIGHT, rows[i].weight);
			end
			send(rows[i].s, rows[i].typed, rows[i].r);
		end

		for (int ph = 0; ph < NumPhases; ph++) begin
			drain();
			case (ph)
				0: begin wsel = 51;  nsel = 205; end
				1: begin wsel = 256; nsel = 0; end
				2: begin wsel = 0;   nsel = 32767; end
				3: begin wsel = 511; nsel = 1; end
				4: begin wsel = 1;   nsel = 2048; end
				default: begin
					wsel = $urandom_range(300);
					nsel = $urandom_range(4000);
				end
			endcase
			write_reg(REG_WEIGHT, wsel);
			write_reg(REG_MIN_NORM, nsel);
			calm = (ph == 3);
			for (int k = 0; k < PhaseItems; k++) begin
				if (ph == 1 && k == 20) stall_req = 1'b1;
				if (ph == 2 && k == 60) drain();
				s = random_sample();
				send(s, 1'b0, zr);
			end
			calm = 1'b0;
		end

		drain();
		repeat (300) @(posedge clk);
		$display("%0d items sent, %0d results checked, %0d with normalized accel",
			n_items, n_results, n_norm);
		$display("%0d register settings incl. weight 0/256/511 and threshold 0/1/32767",
			NumPhases + 3);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ftch_pkg.sv
rtl/ftch_stream_if.sv
rtl/ftch_mac.sv
rtl/ftch_heading.sv
rtl/filtered_tilt_compass_heading.sv
verif/filtered_tilt_compass_heading_test.sv
